// ===== hw/rtl/lrc_pkg.sv =====
// lrc_pkg: shared types and constants for the left-to-right character calculator
// used by the interfaces, the iterative multiply/divide unit, the top level and the checker
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int RESULT_W    = 32;

  typedef logic [VALUE_WIDTH-1:0]       value_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [RESULT_W-1:0]   result_t;

  localparam cnt_t CNT_LAST = cnt_t'(VALUE_WIDTH - 1);

  // ascii codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // request from the sequencer to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

// ===== hw/rtl/lrc_if.sv =====
// lrc_if: valid/ready channel interfaces for characters in and results out
// depends on lrc_pkg for the result type
`timescale 1ns / 1ps

interface lrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface lrc_out_if;
  logic             valid;
  logic             ready;
  lrc_pkg::result_t value;
  logic             div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

// ===== hw/rtl/lrc_muldiv.sv =====
// lrc_muldiv: iterative shift-add multiplier and restoring signed divider sharing one adder
// one bit per cycle; depends on lrc_pkg
`timescale 1ns / 1ps

module lrc_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  lrc_pkg::mdu_req_t req,
  input  lrc_pkg::value_t   opa,
  input  lrc_pkg::value_t   opb,
  output logic              done,
  output lrc_pkg::value_t   result
);

  localparam int VW = lrc_pkg::VALUE_WIDTH;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIX  = 3'b100
  } mstate_t;

  mstate_t         state_r, state_nxt;
  lrc_pkg::cnt_t   cnt_r, cnt_nxt;
  lrc_pkg::value_t rem_r, rem_nxt;
  lrc_pkg::value_t quo_r, quo_nxt;
  lrc_pkg::value_t dvs_r, dvs_nxt;
  lrc_pkg::value_t res_r, res_nxt;
  logic            is_div_r, is_div_nxt;
  logic            neg_r, neg_nxt;
  logic            done_r, done_nxt;

  logic [VW+1:0]   add_x, add_y, add_sum;
  logic            add_inv;
  logic            ge;
  lrc_pkg::value_t abs_a, abs_b;

  assign abs_a = opa[VW-1] ? (~opa + lrc_pkg::value_t'(1)) : opa;
  assign abs_b = opb[VW-1] ? (~opb + lrc_pkg::value_t'(1)) : opb;

  // the one shared adder: subtract for a divide trial, add for a multiply step
  always_comb begin
    if (is_div_r) begin
      add_x   = {1'b0, rem_r, quo_r[VW-1]};
      add_y   = {2'b00, dvs_r};
      add_inv = 1'b1;
    end else begin
      add_x   = {2'b00, rem_r};
      add_y   = {2'b00, dvs_r & {VW{quo_r[0]}}};
      add_inv = 1'b0;
    end
    add_sum = add_x + (add_inv ? ~add_y : add_y) + {{(VW+1){1'b0}}, add_inv};
  end

  assign ge = ~add_sum[VW+1];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    res_nxt    = res_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          is_div_nxt = req.is_div;
          rem_nxt    = '0;
          cnt_nxt    = lrc_pkg::CNT_LAST;
          state_nxt  = M_RUN;
          if (req.is_div) begin
            quo_nxt = abs_a;
            dvs_nxt = abs_b;
            neg_nxt = opa[VW-1] ^ opb[VW-1];
          end else begin
            quo_nxt = opb;
            dvs_nxt = opa;
            neg_nxt = 1'b0;
          end
        end
      end
      M_RUN: begin
        if (is_div_r) begin
          rem_nxt = ge ? add_sum[VW-1:0] : {rem_r[VW-2:0], quo_r[VW-1]};
          quo_nxt = {quo_r[VW-2:0], ge};
        end else begin
          rem_nxt = add_sum[VW-1:0];
          dvs_nxt = {dvs_r[VW-2:0], 1'b0};
          quo_nxt = {1'b0, quo_r[VW-1:1]};
        end
        cnt_nxt = cnt_r - lrc_pkg::cnt_t'(1);
        if (cnt_r == '0) begin
          state_nxt = M_FIX;
        end
      end
      M_FIX: begin
        if (is_div_r) begin
          res_nxt = neg_r ? (~quo_r + lrc_pkg::value_t'(1)) : quo_r;
        end else begin
          res_nxt = rem_r;
        end
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    res_r    <= res_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== hw/rtl/left_to_right_char_calculator.sv =====
// left_to_right_char_calculator: character sequencer, accumulator and output register
// depends on lrc_pkg, lrc_if and lrc_muldiv
`timescale 1ns / 1ps
//
// Usage: in_ch carries one ASCII character per transaction (symbol, end_of_expr).
// Digits build the operand, + - * / apply the pending operator to the accumulator
// strictly left to right, anything else is ignored. The transaction with
// end_of_expr set closes the expression; one result transaction (value,
// div_by_zero) follows on out_ch, and the block starts a fresh expression.
// A digit or ignored character is taken while idle; an operator applies the pending
// operator: + or - in the accumulator, * or / in the shared one-bit-per-cycle unit
// (accept, load, a step per operand bit, sign fix, hand-back and write-back); a zero
// divisor sets the error flag instead. Closing an expression adds an operand application
// and a result load, twice if the last character is an operator. in_ch.ready is low while
// an item is being worked on. The result sits in an output register; if out_ch
// stalls, the next expression is still accepted and computed, and only its own
// result waits until the register is free. Reset (rst_n low, synchronous) clears
// the accumulator, operands and error flag and empties the output register.

module left_to_right_char_calculator (
  input  logic             clk,
  input  logic             rst_n,
  lrc_in_if.sink           in_ch,
  lrc_out_if.source        out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_APPLY = 5'b00010,
    S_BUSY  = 5'b00100,
    S_POST  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  lrc_pkg::value_t   acc_r, acc_nxt;
  lrc_pkg::value_t   cur_r, cur_nxt;
  lrc_pkg::value_t   prev_r, prev_nxt;
  lrc_pkg::op_t      pend_r, pend_nxt;
  lrc_pkg::op_t      new_op_r, new_op_nxt;
  logic              has_r, has_nxt;
  logic              err_r, err_nxt;
  logic              opc_r, opc_nxt;
  logic              end_r, end_nxt;
  logic              out_valid_r, out_valid_nxt;
  lrc_pkg::result_t  out_value_r, out_value_nxt;
  logic              out_div_r, out_div_nxt;

  logic              accept;
  logic              is_digit;
  logic              is_oper;
  lrc_pkg::op_t      sym_op;
  lrc_pkg::value_t   operand;
  lrc_pkg::mdu_req_t mdu_req;
  logic              mdu_done;
  lrc_pkg::value_t   mdu_result;

  lrc_muldiv u_lrc_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mdu_req),
    .opa    (acc_r),
    .opb    (operand),
    .done   (mdu_done),
    .result (mdu_result)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign operand     = has_r ? cur_r : prev_r;
  assign is_digit    = in_ch.symbol inside {[lrc_pkg::CH_ZERO:lrc_pkg::CH_NINE]};

  always_comb begin
    is_oper = 1'b1;
    case (in_ch.symbol)
      lrc_pkg::CH_PLUS:  sym_op = lrc_pkg::OP_ADD;
      lrc_pkg::CH_MINUS: sym_op = lrc_pkg::OP_SUB;
      lrc_pkg::CH_STAR:  sym_op = lrc_pkg::OP_MUL;
      lrc_pkg::CH_SLASH: sym_op = lrc_pkg::OP_DIV;
      default: begin
        sym_op  = lrc_pkg::OP_ADD;
        is_oper = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    new_op_nxt    = new_op_r;
    has_nxt       = has_r;
    err_nxt       = err_r;
    opc_nxt       = opc_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_div_nxt   = out_div_r;
    mdu_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          end_nxt = in_ch.end_of_expr;
          if (is_digit) begin
            // times ten as two shifts and an add
            cur_nxt = (cur_r << 3) + (cur_r << 1) + lrc_pkg::value_t'(in_ch.symbol[3:0]);
            has_nxt = 1'b1;
            if (in_ch.end_of_expr) begin
              state_nxt = S_APPLY;
            end
          end else if (is_oper) begin
            new_op_nxt = sym_op;
            opc_nxt    = 1'b1;
            state_nxt  = S_APPLY;
          end else if (in_ch.end_of_expr) begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        prev_nxt = operand;
        cur_nxt  = '0;
        has_nxt  = 1'b0;
        case (pend_r)
          lrc_pkg::OP_ADD: begin
            acc_nxt   = acc_r + operand;
            state_nxt = S_POST;
          end
          lrc_pkg::OP_SUB: begin
            acc_nxt   = acc_r - operand;
            state_nxt = S_POST;
          end
          lrc_pkg::OP_MUL: begin
            mdu_req.start  = 1'b1;
            mdu_req.is_div = 1'b0;
            state_nxt      = S_BUSY;
          end
          default: begin
            if (operand == '0) begin
              err_nxt   = 1'b1;
              acc_nxt   = '0;
              state_nxt = S_POST;
            end else begin
              mdu_req.start  = 1'b1;
              mdu_req.is_div = 1'b1;
              state_nxt      = S_BUSY;
            end
          end
        endcase
      end
      S_BUSY: begin
        if (mdu_done) begin
          acc_nxt   = mdu_result;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (opc_r) begin
          // operator character: its operator becomes pending, then close if last
          pend_nxt  = new_op_r;
          opc_nxt   = 1'b0;
          state_nxt = end_r ? S_APPLY : S_IDLE;
        end else begin
          state_nxt = end_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = err_r ? '0 : lrc_pkg::result_t'($signed(acc_r));
          out_div_nxt   = err_r;
          acc_nxt       = '0;
          cur_nxt       = '0;
          prev_nxt      = '0;
          pend_nxt      = lrc_pkg::OP_ADD;
          has_nxt       = 1'b0;
          err_nxt       = 1'b0;
          end_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      pend_r      <= lrc_pkg::OP_ADD;
      has_r       <= 1'b0;
      err_r       <= 1'b0;
      opc_r       <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      pend_r      <= pend_nxt;
      has_r       <= has_nxt;
      err_r       <= err_nxt;
      opc_r       <= opc_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    new_op_r    <= new_op_nxt;
    out_value_r <= out_value_nxt;
    out_div_r   <= out_div_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.div_by_zero = out_div_r;

endmodule

// ===== hw/rtl/lrc_checker.sv =====
// lrc_checker: port-level assertions for the left-to-right character calculator
// depends on lrc_pkg; bound to left_to_right_char_calculator below
`timescale 1ns / 1ps

module lrc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [7:0]       in_symbol,
  input logic             in_end,
  input logic             out_valid,
  input logic             out_ready,
  input lrc_pkg::result_t out_value,
  input logic             out_div
);

  logic in_oper;

  assign in_oper = (in_symbol == lrc_pkg::CH_PLUS) || (in_symbol == lrc_pkg::CH_MINUS) ||
                   (in_symbol == lrc_pkg::CH_STAR) || (in_symbol == lrc_pkg::CH_SLASH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_div))
    else $error("result changed while stalled");

  // a zero divisor forces a zero value
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div |-> out_value == '0)
    else $error("div_by_zero result with nonzero value");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an operator or the closing character keeps the block busy for the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_oper || in_end) |=> !in_ready)
    else $error("ready right after an operator or end transaction");

endmodule

bind left_to_right_char_calculator lrc_checker u_lrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_symbol (in_ch.symbol),
  .in_end    (in_ch.end_of_expr),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_div   (out_ch.div_by_zero)
);

// ===== tb/sv/left_to_right_char_calculator_tb.sv =====
// left_to_right_char_calculator_tb: self-checking bench for the character calculator,
// directed rows then random expressions, each result checked against a typed value or an in-bench predictor
// depends on lrc_pkg, lrc_if and the left_to_right_char_calculator rtl
`timescale 1ns / 1ps

module left_to_right_char_calculator_tb;

  typedef struct packed {
    lrc_pkg::result_t value;
    logic             div_by_zero;
  } calc_res_t;

  typedef struct packed {
    logic [7:0]       sym;
    logic             last;
    logic             typed;
    lrc_pkg::result_t value;
    logic             div_by_zero;
  } directed_row_t;

  localparam int N_DIRECTED = 29;

  // typed results only where they are obvious; the rest go through the predictor
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty expression right after reset, ignored top byte as end marker
    '{8'hFF, 1'b1, 1'b1, 32'sd0, 1'b0},
    // zero divisor
    '{"9", 1'b0, 1'b0, '0, 1'b0}, '{lrc_pkg::CH_SLASH, 1'b0, 1'b0, '0, 1'b0},
    '{"0", 1'b1, 1'b1, 32'sd0, 1'b1},
    // operators back to back reuse the last operand, end on an ignored byte
    '{"5", 1'b0, 1'b0, '0, 1'b0}, '{lrc_pkg::CH_STAR, 1'b0, 1'b0, '0, 1'b0},
    '{lrc_pkg::CH_MINUS, 1'b0, 1'b0, '0, 1'b0}, '{8'h00, 1'b1, 1'b0, '0, 1'b0},
    // most negative divided by minus one
    '{"2", 1'b0, 1'b0, '0, 1'b0}, '{"1", 1'b0, 1'b0, '0, 1'b0},
    '{"4", 1'b0, 1'b0, '0, 1'b0}, '{"7", 1'b0, 1'b0, '0, 1'b0},
    '{"4", 1'b0, 1'b0, '0, 1'b0}, '{"8", 1'b0, 1'b0, '0, 1'b0},
    '{"3", 1'b0, 1'b0, '0, 1'b0}, '{"6", 1'b0, 1'b0, '0, 1'b0},
    '{"4", 1'b0, 1'b0, '0, 1'b0}, '{"8", 1'b0, 1'b0, '0, 1'b0},
    '{lrc_pkg::CH_SLASH, 1'b0, 1'b0, '0, 1'b0},
    '{"4", 1'b0, 1'b0, '0, 1'b0}, '{"2", 1'b0, 1'b0, '0, 1'b0},
    '{"9", 1'b0, 1'b0, '0, 1'b0}, '{"4", 1'b0, 1'b0, '0, 1'b0},
    '{"9", 1'b0, 1'b0, '0, 1'b0}, '{"6", 1'b0, 1'b0, '0, 1'b0},
    '{"7", 1'b0, 1'b0, '0, 1'b0}, '{"2", 1'b0, 1'b0, '0, 1'b0},
    '{"9", 1'b0, 1'b0, '0, 1'b0}, '{"5", 1'b1, 1'b1, 32'sh8000_0000, 1'b0}
  };

  logic clk;
  logic rst_n;

  lrc_in_if  in_ch ();
  lrc_out_if out_ch ();

  left_to_right_char_calculator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  lrc_pkg::value_t acc_val;
  lrc_pkg::value_t cur_val;
  lrc_pkg::value_t prev_val;
  lrc_pkg::op_t    pend_op;
  logic            has_digits;
  logic            div_err;

  calc_res_t pending_results [$];

  int  errors      = 0;
  int  chars_sent  = 0;
  int  exprs_done  = 0;
  int  dbz_seen    = 0;
  bit  steady      = 1'b0;
  bit  drained_once = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic lrc_pkg::value_t magnitude_of(lrc_pkg::value_t v);
    return v[lrc_pkg::VALUE_WIDTH-1] ? lrc_pkg::value_t'(-v) : v;
  endfunction

  function automatic void clear_calc();
    acc_val    = '0;
    cur_val    = '0;
    prev_val   = '0;
    pend_op    = lrc_pkg::OP_ADD;
    has_digits = 1'b0;
    div_err    = 1'b0;
  endfunction

  function automatic void apply_operand();
    lrc_pkg::value_t opnd;
    lrc_pkg::value_t quot;
    opnd = has_digits ? cur_val : prev_val;
    case (pend_op)
      lrc_pkg::OP_ADD: acc_val = acc_val + opnd;
      lrc_pkg::OP_SUB: acc_val = acc_val - opnd;
      lrc_pkg::OP_MUL: acc_val = acc_val * opnd;
      default: begin
        if (opnd == '0) begin
          div_err = 1'b1;
          acc_val = '0;
        end else begin
          quot = magnitude_of(acc_val) / magnitude_of(opnd);
          if (acc_val[lrc_pkg::VALUE_WIDTH-1] != opnd[lrc_pkg::VALUE_WIDTH-1]) quot = -quot;
          acc_val = quot;
        end
      end
    endcase
    prev_val   = opnd;
    cur_val    = '0;
    has_digits = 1'b0;
  endfunction

  // advances the predictor by one character; returns 1 when a result is due
  function automatic bit calc_char(logic [7:0] s, logic last, output calc_res_t res);
    res = '0;
    if (s >= lrc_pkg::CH_ZERO && s <= lrc_pkg::CH_NINE) begin
      cur_val    = cur_val * 10 + lrc_pkg::value_t'(s - lrc_pkg::CH_ZERO);
      has_digits = 1'b1;
    end else if (s == lrc_pkg::CH_PLUS || s == lrc_pkg::CH_MINUS ||
                 s == lrc_pkg::CH_STAR || s == lrc_pkg::CH_SLASH) begin
      apply_operand();
      case (s)
        lrc_pkg::CH_PLUS:  pend_op = lrc_pkg::OP_ADD;
        lrc_pkg::CH_MINUS: pend_op = lrc_pkg::OP_SUB;
        lrc_pkg::CH_STAR:  pend_op = lrc_pkg::OP_MUL;
        default:           pend_op = lrc_pkg::OP_DIV;
      endcase
    end
    if (!last) return 1'b0;
    apply_operand();
    res.div_by_zero = div_err;
    res.value       = div_err ? lrc_pkg::result_t'(0) : lrc_pkg::result_t'($signed(acc_val));
    clear_calc();
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0:       return lrc_pkg::CH_PLUS;
      1:       return lrc_pkg::CH_MINUS;
      2:       return lrc_pkg::CH_STAR;
      default: return lrc_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] s, input logic last, input logic typed,
                           input calc_res_t typed_res);
    calc_res_t res;
    if (!steady && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= s;
    in_ch.end_of_expr <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ((s >= lrc_pkg::CH_ZERO && s <= lrc_pkg::CH_NINE) || s == lrc_pkg::CH_PLUS ||
        s == lrc_pkg::CH_MINUS || s == lrc_pkg::CH_STAR || s == lrc_pkg::CH_SLASH)
      chars_sent++;
    if (calc_char(s, last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // hold the sender off until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic gen_expr();
    logic [7:0] seq [$];
    int n_terms;
    int n_dig;
    int kind;
    if ($urandom_range(0, 9) == 0) begin
      // noise: arbitrary bytes, often broken expressions
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_terms = $urandom_range(1, 5);
      for (int t = 0; t < n_terms; t++) begin
        if (t != 0) seq.push_back(rand_op());
        kind = $urandom_range(0, 19);
        if (kind == 0) n_dig = 0;
        else if (kind == 1) n_dig = $urandom_range(10, 12);
        else n_dig = $urandom_range(1, 3);
        if (kind == 2) seq.push_back(lrc_pkg::CH_ZERO);
        else repeat (n_dig) seq.push_back(lrc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 19) == 0) seq.push_back(8'($urandom_range(0, 255)));
      end
      // trailing operator reuses the last operand
      if ($urandom_range(0, 9) == 0) seq.push_back(rand_op());
    end
    if (seq.size() == 0) seq.push_back(rand_op());
    foreach (seq[i]) send_char(seq[i], i == seq.size() - 1, 1'b0, '0);
  endtask

  task automatic check_result(input lrc_pkg::result_t v, input logic d);
    calc_res_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transaction value=%0d div_by_zero=%0b", $time, v, d);
    end else begin
      want = pending_results.pop_front();
      exprs_done++;
      if (d) dbz_seen++;
      if (v !== want.value) begin
        errors++;
        $display("%0t: value mismatch: expected %0d, actual %0d", $time, want.value, v);
      end
      if (d !== want.div_by_zero) begin
        errors++;
        $display("%0t: div_by_zero mismatch: expected %0b, actual %0b",
                 $time, want.div_by_zero, d);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result(out_ch.value, out_ch.div_by_zero);
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  initial begin
    clear_calc();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.end_of_expr <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++)
      send_char(directed_rows[r].sym, directed_rows[r].last, directed_rows[r].typed,
                calc_res_t'({directed_rows[r].value, directed_rows[r].div_by_zero}));
    drain_results();

    while (chars_sent < 700 + 29) begin
      steady = (chars_sent > 250 && chars_sent < 400);
      if (!drained_once && chars_sent > 500) begin
        drained_once = 1'b1;
        drain_results();
      end
      gen_expr();
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d expressions built from %0d digit and operator transactions,",
             exprs_done, chars_sent);
    $display("%0d of them ending with a division by zero", dbz_seen);
    if (errors == 0) begin
      $display("left_to_right_char_calculator regression: pass");
    end else begin
      $display("left_to_right_char_calculator regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("left_to_right_char_calculator regression: fail");
    $finish;
  end

endmodule
